/* hw/rtl/pm_pkg.sv */
// Shared types and constants for the polynomial multiplier.
package pm_pkg;

  // Operand tag carried with each input word
  localparam logic OPD_FIRST  = 1'b0;
  localparam logic OPD_SECOND = 1'b1;

  // Multiply width of the shared multiplier
  localparam int unsigned MUL_W = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_WAIT
  } pm_state_t;

  // Partial product selector: low*low, low*high, high*low
  typedef enum logic [1:0] {
    PP_LL,
    PP_LH,
    PP_HL
  } pm_pp_t;

  // One multiply-accumulate step handed to the MAC unit
  typedef struct packed {
    logic   valid;
    logic   first;
    logic   last;
    pm_pp_t pp;
  } pm_tok_t;

endpackage

/* hw/rtl/pm_if.sv */
// Valid/ready channel interfaces for coefficient input and product output.
interface pm_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coef;
  logic               operand;
  logic               last;

  modport source (output valid, coef, operand, last, input ready);
  modport sink   (input valid, coef, operand, last, output ready);
endinterface

interface pm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] product_coef;
  logic               last_out;
  logic               truncated;

  modport source (output valid, product_coef, last_out, truncated, input ready);
  modport sink   (input valid, product_coef, last_out, truncated, output ready);
endinterface

/* hw/rtl/pm_mac.sv */
// Shared multiply-accumulate unit: one registered multiplier and one accumulator.
module pm_mac
  import pm_pkg::*;
#(
  parameter int unsigned COEF_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [COEF_WIDTH-1:0] a,
  input  logic [COEF_WIDTH-1:0] b,
  input  pm_tok_t               tok,
  output logic [COEF_WIDTH-1:0] acc,
  output logic                  done
);

  localparam int unsigned MW = (COEF_WIDTH > MUL_W) ? MUL_W : COEF_WIDTH;

  logic [MW-1:0]         op_a;
  logic [MW-1:0]         op_b;
  logic [2*MW-1:0]       prod_r;
  logic [2*MW-1:0]       prod_nxt;
  pm_tok_t               tok2_r;
  logic [COEF_WIDTH-1:0] addend;
  logic [COEF_WIDTH-1:0] acc_r;
  logic [COEF_WIDTH-1:0] acc_nxt;
  logic                  done_r;

  generate
    if (COEF_WIDTH > MUL_W) begin : g_split
      // Only the low COEF_WIDTH bits matter, so the high*high term drops out
      always_comb begin
        case (tok.pp)
          PP_LH: begin
            op_a = a[MW-1:0];
            op_b = MW'(b[COEF_WIDTH-1:MUL_W]);
          end
          PP_HL: begin
            op_a = MW'(a[COEF_WIDTH-1:MUL_W]);
            op_b = b[MW-1:0];
          end
          default: begin
            op_a = a[MW-1:0];
            op_b = b[MW-1:0];
          end
        endcase
      end
    end else begin : g_whole
      assign op_a = a;
      assign op_b = b;
    end
  endgenerate

  assign prod_nxt = op_a * op_b;

  // Cross terms sit MUL_W bits up
  assign addend = (tok2_r.pp == PP_LL) ? COEF_WIDTH'(prod_r)
                                       : COEF_WIDTH'({prod_r, {MUL_W{1'b0}}});

  assign acc_nxt = (tok2_r.first ? '0 : acc_r) + addend;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (tok2_r.valid) begin
      acc_r <= acc_nxt;
    end
    if (!rst_n) begin
      tok2_r <= '0;
      done_r <= 1'b0;
    end else begin
      tok2_r <= tok;
      done_r <= tok2_r.valid & tok2_r.last;
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

/* hw/rtl/polynomial_multiply.sv */
// Polynomial multiplier: loads two coefficient lists and emits their convolution.
// Operation: each loading word is stored; the triggering word (a last second-operand
//   word) starts a product whose coefficient k sums T(k) terms of P partial products,
//   P = 1 (3 when COEF_WIDTH > 32), then drains the MAC unit and waits for the output.
// Throughput: one loading word per cycle; input stalls while a product runs.
// Reset (rst_n low, synchronous): counts, overflow flag, sequencer and output valid clear.
module polynomial_multiply
  import pm_pkg::*;
#(
  parameter int unsigned MAX_TERMS  = 32,
  parameter int unsigned COEF_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  pm_in_if.sink      in_if,
  pm_out_if.source   out_if
);

  // Store index, fill count and product index widths
  localparam int unsigned IDX_W = $clog2(MAX_TERMS);
  localparam int unsigned CNT_W = $clog2(MAX_TERMS + 1);
  localparam int unsigned K_W   = $clog2(2 * MAX_TERMS);
  localparam pm_pp_t      PP_LAST = (COEF_WIDTH > MUL_W) ? PP_HL : PP_LL;

  // Coefficient stores; only entries below the latched product lengths are used
  logic [COEF_WIDTH-1:0] first_mem  [MAX_TERMS];
  logic [COEF_WIDTH-1:0] second_mem [MAX_TERMS];
  logic [COEF_WIDTH-1:0] a_q;
  logic [COEF_WIDTH-1:0] b_q;
  logic [COEF_WIDTH-1:0] a_op;
  logic [COEF_WIDTH-1:0] coef_cw;

  pm_state_t        state_r, state_nxt;
  logic [CNT_W-1:0] first_cnt_r, first_cnt_nxt;
  logic [CNT_W-1:0] second_cnt_r, second_cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] lena_r, lena_nxt;
  logic [CNT_W-1:0] lenb_r, lenb_nxt;
  logic             zero_first_r, zero_first_nxt;
  logic             trunc_r, trunc_nxt;
  logic [K_W-1:0]   k_r, k_nxt;
  logic [K_W-1:0]   last_k_r, last_k_nxt;
  logic [K_W-1:0]   k_inc;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  pm_pp_t           pp_r, pp_nxt;
  logic             term_first_r, term_first_nxt;
  logic             term_last;

  pm_tok_t tok_issue;
  pm_tok_t tok_s1_r;

  logic                  accept;
  logic                  first_full;
  logic                  second_full;
  logic                  out_load;
  logic [COEF_WIDTH-1:0] mac_acc;
  logic                  mac_done;

  logic                  out_valid_r, out_valid_nxt;
  logic signed [31:0]    out_coef_r;
  logic                  out_last_r;
  logic                  out_trunc_r;

  assign accept      = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == ST_IDLE);
  assign first_full  = (first_cnt_r == CNT_W'(MAX_TERMS));
  assign second_full = (second_cnt_r == CNT_W'(MAX_TERMS));

  // Resize the incoming word to the internal coefficient width
  assign coef_cw = COEF_WIDTH'(in_if.coef);

  // Store writes at the fill count; registered reads at the term indices
  always_ff @(posedge clk) begin
    if (accept && in_if.operand == OPD_FIRST && !first_full) begin
      first_mem[first_cnt_r[IDX_W-1:0]] <= coef_cw;
    end
    if (accept && in_if.operand == OPD_SECOND && !second_full) begin
      second_mem[second_cnt_r[IDX_W-1:0]] <= coef_cw;
    end
    a_q <= first_mem[i_r];
    b_q <= second_mem[j_r];
  end

  // An empty first operand reads as a single zero
  assign a_op = zero_first_r ? '0 : a_q;

  // Last term of this coefficient: either index has hit its edge
  assign term_last = (i_r == IDX_W'(lena_r - CNT_W'(1))) || (j_r == '0);
  assign k_inc     = k_r + K_W'(1);
  assign out_load  = (state_r == ST_WAIT) && (!out_valid_r || out_if.ready);

  always_comb begin
    state_nxt      = state_r;
    first_cnt_nxt  = first_cnt_r;
    second_cnt_nxt = second_cnt_r;
    ovf_nxt        = ovf_r;
    lena_nxt       = lena_r;
    lenb_nxt       = lenb_r;
    zero_first_nxt = zero_first_r;
    trunc_nxt      = trunc_r;
    k_nxt          = k_r;
    last_k_nxt     = last_k_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    pp_nxt         = pp_r;
    term_first_nxt = term_first_r;
    tok_issue      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_if.operand == OPD_FIRST) begin
            // Store or drop a first-operand word
            if (!first_full) begin
              first_cnt_nxt = first_cnt_r + CNT_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end else begin
            if (!second_full) begin
              second_cnt_nxt = second_cnt_r + CNT_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
            if (in_if.last) begin
              // Latch the product geometry, then empty both stores
              zero_first_nxt = (first_cnt_r == '0);
              lena_nxt       = zero_first_nxt ? CNT_W'(1) : first_cnt_r;
              lenb_nxt       = second_full ? second_cnt_r : second_cnt_r + CNT_W'(1);
              trunc_nxt      = ovf_r | second_full;
              last_k_nxt     = K_W'(lena_nxt) + K_W'(lenb_nxt) - K_W'(2);
              k_nxt          = '0;
              i_nxt          = '0;
              j_nxt          = '0;
              pp_nxt         = PP_LL;
              term_first_nxt = 1'b1;
              first_cnt_nxt  = '0;
              second_cnt_nxt = '0;
              ovf_nxt        = 1'b0;
              state_nxt      = ST_MAC;
            end
          end
        end
      end

      ST_MAC: begin
        // Issue one partial product per cycle to the MAC unit
        tok_issue.valid = 1'b1;
        tok_issue.first = term_first_r && (pp_r == PP_LL);
        tok_issue.last  = term_last && (pp_r == PP_LAST);
        tok_issue.pp    = pp_r;
        if (pp_r != PP_LAST) begin
          pp_nxt = pm_pp_t'(pp_r + 2'd1);
        end else begin
          pp_nxt         = PP_LL;
          term_first_nxt = 1'b0;
          if (term_last) begin
            state_nxt = ST_DRAIN;
          end else begin
            i_nxt = i_r + IDX_W'(1);
            j_nxt = j_r - IDX_W'(1);
          end
        end
      end

      ST_DRAIN: begin
        if (mac_done) begin
          state_nxt = ST_WAIT;
        end
      end

      ST_WAIT: begin
        // Hand the sum to the output register, then start the next coefficient or, after the last, go idle
        if (out_load) begin
          if (k_r == last_k_r) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt          = k_inc;
            term_first_nxt = 1'b1;
            state_nxt      = ST_MAC;
            if (k_inc < K_W'(lenb_r)) begin
              i_nxt = '0;
              j_nxt = IDX_W'(k_inc);
            end else begin
              i_nxt = IDX_W'(k_inc - K_W'(lenb_r) + K_W'(1));
              j_nxt = IDX_W'(lenb_r - CNT_W'(1));
            end
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      first_cnt_r  <= '0;
      second_cnt_r <= '0;
      ovf_r        <= 1'b0;
      tok_s1_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      first_cnt_r  <= first_cnt_nxt;
      second_cnt_r <= second_cnt_nxt;
      ovf_r        <= ovf_nxt;
      tok_s1_r     <= tok_issue;
    end
  end

  // Product geometry and term indices; only read once a product is running
  always_ff @(posedge clk) begin
    lena_r       <= lena_nxt;
    lenb_r       <= lenb_nxt;
    zero_first_r <= zero_first_nxt;
    trunc_r      <= trunc_nxt;
    k_r          <= k_nxt;
    last_k_r     <= last_k_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    pp_r         <= pp_nxt;
    term_first_r <= term_first_nxt;
  end

  pm_mac #(
    .COEF_WIDTH(COEF_WIDTH)
  ) u_mac (
    .clk  (clk),
    .rst_n(rst_n),
    .a    (a_op),
    .b    (b_q),
    .tok  (tok_s1_r),
    .acc  (mac_acc),
    .done (mac_done)
  );

  // Output register: drop on take, fill on load
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (out_load) begin
      out_coef_r  <= 32'(signed'(mac_acc));
      out_last_r  <= (k_r == last_k_r);
      out_trunc_r <= trunc_r;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.product_coef = out_coef_r;
  assign out_if.last_out     = out_last_r;
  assign out_if.truncated    = out_trunc_r;

endmodule

/* hw/rtl/pm_checker.sv */
// Port-level checks for the polynomial multiplier, bound to the top level.
module pm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_operand,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_product_coef,
  input logic        out_last_out,
  input logic        out_truncated
);

  // Reset empties the output register
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  // A trigger word holds off input while the product runs
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_operand && in_last) |=> !in_ready)
    else $error("input accepted straight after a trigger word");

  // Mid-product result pending means the block is still busy
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_out) |-> !in_ready)
    else $error("input ready while a product is unfinished");

  // A stalled result word holds still
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_product_coef) && $stable(out_last_out) &&
       $stable(out_truncated)))
    else $error("stalled result word changed");

endmodule

bind polynomial_multiply pm_checker u_pm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .in_operand      (in_if.operand),
  .in_last         (in_if.last),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_product_coef(out_if.product_coef),
  .out_last_out    (out_if.last_out),
  .out_truncated   (out_if.truncated)
);
